>>> sv/ljs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljs_pkg
// Shared types and constants of the Laplace Jacobi grid solver.
// ----------------------------------------------------------------------------
package ljs_pkg;

  localparam int CELL_W   = 24;
  localparam int SUM_W    = CELL_W + 2;
  localparam int DIM_W    = 7;
  localparam int COORD_W  = 6;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SWEEP = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_EDGE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EDGE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_EDGE  = 3'd6;

  localparam logic [DIM_W-1:0]          RST_GRID_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0]          RST_GRID_HEIGHT = 7'd64;
  localparam logic [COUNT_W-1:0]        RST_SWEEP_COUNT = 16'd1;
  localparam logic signed [CELL_W-1:0]  RST_LEFT_EDGE   = 24'sd1310720;
  localparam logic signed [CELL_W-1:0]  RST_TOP_EDGE    = 24'sd327680;
  localparam logic signed [CELL_W-1:0]  RST_RIGHT_EDGE  = 24'sd0;
  localparam logic signed [CELL_W-1:0]  RST_BOTTOM_EDGE = 24'sd2949120;

  typedef struct packed {
    action_t                    action;
    logic [COORD_W-1:0]         col;
    logic [COORD_W-1:0]         row;
    logic signed [CELL_W-1:0]   cell_value;
  } cmd_t;

  typedef struct packed {
    logic signed [CELL_W-1:0]   read_value;
    logic                       status;
  } result_t;

  typedef struct packed {
    logic signed [CELL_W-1:0]   left_edge;
    logic signed [CELL_W-1:0]   top_edge;
    logic signed [CELL_W-1:0]   right_edge;
    logic signed [CELL_W-1:0]   bottom_edge;
  } edge_cfg_t;

  typedef struct packed {
    logic busy;
    logic wr_en;
    logic swap;
    logic done;
  } eng_ctl_t;

endpackage

>>> sv/ljs_grid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljs_grid_mem
// Cell store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ljs_grid_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [ljs_pkg::CELL_W-1:0] wr_data,
  input  logic [AW-1:0]                     rd_addr0,
  input  logic [AW-1:0]                     rd_addr1,
  output logic signed [ljs_pkg::CELL_W-1:0] rd_data0,
  output logic signed [ljs_pkg::CELL_W-1:0] rd_data1
);

  logic [ljs_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

>>> sv/ljs_sweep_eng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljs_sweep_eng
// Pass sequencer: walks the grid, reads four neighbours two at a time,
// writes each new cell to the other store and drains between passes.
// ----------------------------------------------------------------------------
module ljs_sweep_eng #(
  parameter int MAX_WIDTH = 64,
  parameter int AW        = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ljs_pkg::DIM_W-1:0]          w,
  input  logic [ljs_pkg::DIM_W-1:0]          h,
  input  logic [ljs_pkg::COUNT_W-1:0]        count,
  input  ljs_pkg::edge_cfg_t                 edges,
  input  logic signed [ljs_pkg::CELL_W-1:0]  src_rd0,
  input  logic signed [ljs_pkg::CELL_W-1:0]  src_rd1,
  output logic [AW-1:0]                      rd_addr0,
  output logic [AW-1:0]                      rd_addr1,
  output logic [AW-1:0]                      wr_addr,
  output logic signed [ljs_pkg::CELL_W-1:0]  wr_data,
  output ljs_pkg::eng_ctl_t                  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t                            state;
  logic [ljs_pkg::DIM_W-1:0]         x;
  logic [ljs_pkg::DIM_W-1:0]         y;
  logic                              half;
  logic [ljs_pkg::COUNT_W-1:0]       passes_left;
  logic                              drain_cnt;
  logic                              p1_valid;
  logic                              p1_half;
  logic                              p1_interior;
  logic [AW-1:0]                     p1_addr;
  logic signed [ljs_pkg::CELL_W-1:0] p1_edge;
  logic signed [ljs_pkg::SUM_W-1:0]  acc;
  logic                              wr_en;

  logic [ljs_pkg::DIM_W-1:0]         w_last;
  logic [ljs_pkg::DIM_W-1:0]         h_last;
  logic [AW-1:0]                     base;
  logic                              xe;
  logic                              ye;
  logic                              interior;
  logic signed [ljs_pkg::CELL_W-1:0] edge_val;
  logic signed [ljs_pkg::SUM_W-1:0]  rd_pair;
  logic signed [ljs_pkg::SUM_W-1:0]  sum;

  always_comb begin
    w_last   = w - ljs_pkg::DIM_W'(1);
    h_last   = h - ljs_pkg::DIM_W'(1);
    base     = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    xe       = (x == '0) || (x == w_last);
    ye       = (y == '0) || (y == h_last);
    interior = !xe && !ye;
    if (xe && ye) begin
      edge_val = '0;
    end else if (x == '0) begin
      edge_val = edges.left_edge;
    end else if (y == '0) begin
      edge_val = edges.top_edge;
    end else if (x == w_last) begin
      edge_val = edges.right_edge;
    end else begin
      edge_val = edges.bottom_edge;
    end
    if (!half) begin
      rd_addr0 = base - AW'(1);
      rd_addr1 = base + AW'(1);
    end else begin
      rd_addr0 = base - AW'(MAX_WIDTH);
      rd_addr1 = base + AW'(MAX_WIDTH);
    end
    rd_pair = {{2{src_rd0[ljs_pkg::CELL_W-1]}}, src_rd0}
            + {{2{src_rd1[ljs_pkg::CELL_W-1]}}, src_rd1};
    sum     = acc + rd_pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p1_valid <= 1'b0;
      wr_en    <= 1'b0;
    end else begin
      p1_valid    <= (state == S_RUN);
      wr_en       <= p1_valid && p1_half;
      p1_half     <= half;
      p1_interior <= interior;
      p1_addr     <= base;
      p1_edge     <= edge_val;
      if (p1_valid && !p1_half) begin
        acc <= rd_pair;
      end
      wr_addr <= p1_addr;
      wr_data <= p1_interior ? sum[ljs_pkg::SUM_W-1:2] : p1_edge;
      case (state)
        S_IDLE: begin
          if (start) begin
            x           <= '0;
            y           <= '0;
            half        <= 1'b0;
            passes_left <= count;
            state       <= (count == '0) ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          half <= ~half;
          if (half) begin
            if (x == w_last) begin
              x <= '0;
              if (y == h_last) begin
                drain_cnt <= 1'b0;
                state     <= S_DRAIN;
              end else begin
                y <= y + ljs_pkg::DIM_W'(1);
              end
            end else begin
              x <= x + ljs_pkg::DIM_W'(1);
            end
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            passes_left <= passes_left - ljs_pkg::COUNT_W'(1);
            x           <= '0;
            y           <= '0;
            half        <= 1'b0;
            state       <= (passes_left == ljs_pkg::COUNT_W'(1)) ? S_FIN : S_RUN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ctl.busy  = (state != S_IDLE);
    ctl.wr_en = wr_en;
    ctl.swap  = (state == S_DRAIN) && drain_cnt;
    ctl.done  = (state == S_FIN);
  end

endmodule

>>> sv/laplace_jacobi_grid_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplace_jacobi_grid_solver_top
// Two ping-pong cell stores with cell write/read items and Jacobi sweeps.
// ----------------------------------------------------------------------------
// write/read item: result in the cycle after accept, one item per cycle while no sweep is busy
// sweep item: result after all passes of the sweep, paced by the two read
//   ports of each store (four neighbour reads are split into two pairs per cell)
// the receiver cannot stall; done marks each result for one cycle
// reset clears control and loads register defaults; stores are not cleared
module laplace_jacobi_grid_solver_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ljs_pkg::cmd_t                      cmd,
  output logic                               done,
  output ljs_pkg::result_t                   result,
  input  logic                               cfg_write,
  input  logic [ljs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ljs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [ljs_pkg::DIM_W-1:0]         grid_width;
  logic [ljs_pkg::DIM_W-1:0]         grid_height;
  logic [ljs_pkg::COUNT_W-1:0]       sweep_count;
  ljs_pkg::edge_cfg_t                edges;
  logic                              current_is_b;
  logic                              rd_pending;
  logic                              status;

  logic [ljs_pkg::DIM_W-1:0]         w_eff;
  logic [ljs_pkg::DIM_W-1:0]         h_eff;
  logic                              accept;
  logic                              item_ok;
  logic                              item_wr;
  logic                              sweep_start;
  logic [AW-1:0]                     item_addr;

  ljs_pkg::eng_ctl_t                 eng_ctl;
  logic [AW-1:0]                     eng_rd_addr0;
  logic [AW-1:0]                     eng_rd_addr1;
  logic [AW-1:0]                     eng_wr_addr;
  logic signed [ljs_pkg::CELL_W-1:0] eng_wr_data;

  logic                              a_we;
  logic                              b_we;
  logic [AW-1:0]                     wr_addr_a;
  logic [AW-1:0]                     wr_addr_b;
  logic signed [ljs_pkg::CELL_W-1:0] wr_data_a;
  logic signed [ljs_pkg::CELL_W-1:0] wr_data_b;
  logic [AW-1:0]                     rd_addr0;
  logic signed [ljs_pkg::CELL_W-1:0] a_rd0;
  logic signed [ljs_pkg::CELL_W-1:0] a_rd1;
  logic signed [ljs_pkg::CELL_W-1:0] b_rd0;
  logic signed [ljs_pkg::CELL_W-1:0] b_rd1;
  logic signed [ljs_pkg::CELL_W-1:0] src_rd0;
  logic signed [ljs_pkg::CELL_W-1:0] src_rd1;

  // grid size saturation
  always_comb begin
    if (grid_width < ljs_pkg::MIN_DIM) begin
      w_eff = ljs_pkg::MIN_DIM;
    end else if (int'(grid_width) > MAX_WIDTH) begin
      w_eff = ljs_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < ljs_pkg::MIN_DIM) begin
      h_eff = ljs_pkg::MIN_DIM;
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      h_eff = ljs_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  always_comb begin
    busy        = eng_ctl.busy;
    accept      = start && !busy;
    item_ok     = ({1'b0, cmd.col} < w_eff) && ({1'b0, cmd.row} < h_eff);
    item_wr     = accept && (cmd.action == ljs_pkg::ACT_WRITE) && item_ok;
    sweep_start = accept && (cmd.action == ljs_pkg::ACT_SWEEP);
    item_addr   = AW'(cmd.row) * AW'(MAX_WIDTH) + AW'(cmd.col);
  end

  // store roles: current store takes items and is the sweep source
  always_comb begin
    a_we      = current_is_b ? eng_ctl.wr_en : item_wr;
    wr_addr_a = current_is_b ? eng_wr_addr : item_addr;
    wr_data_a = current_is_b ? eng_wr_data : cmd.cell_value;
    b_we      = current_is_b ? item_wr : eng_ctl.wr_en;
    wr_addr_b = current_is_b ? item_addr : eng_wr_addr;
    wr_data_b = current_is_b ? cmd.cell_value : eng_wr_data;
    rd_addr0  = busy ? eng_rd_addr0 : item_addr;
    src_rd0   = current_is_b ? b_rd0 : a_rd0;
    src_rd1   = current_is_b ? b_rd1 : a_rd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width        <= ljs_pkg::RST_GRID_WIDTH;
      grid_height       <= ljs_pkg::RST_GRID_HEIGHT;
      sweep_count       <= ljs_pkg::RST_SWEEP_COUNT;
      edges.left_edge   <= ljs_pkg::RST_LEFT_EDGE;
      edges.top_edge    <= ljs_pkg::RST_TOP_EDGE;
      edges.right_edge  <= ljs_pkg::RST_RIGHT_EDGE;
      edges.bottom_edge <= ljs_pkg::RST_BOTTOM_EDGE;
      current_is_b      <= 1'b0;
      done              <= 1'b0;
      rd_pending        <= 1'b0;
      status            <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ljs_pkg::CFG_GRID_WIDTH:  grid_width        <= cfg_data[ljs_pkg::DIM_W-1:0];
          ljs_pkg::CFG_GRID_HEIGHT: grid_height       <= cfg_data[ljs_pkg::DIM_W-1:0];
          ljs_pkg::CFG_SWEEP_COUNT: sweep_count       <= cfg_data[ljs_pkg::COUNT_W-1:0];
          ljs_pkg::CFG_LEFT_EDGE:   edges.left_edge   <= cfg_data;
          ljs_pkg::CFG_TOP_EDGE:    edges.top_edge    <= cfg_data;
          ljs_pkg::CFG_RIGHT_EDGE:  edges.right_edge  <= cfg_data;
          ljs_pkg::CFG_BOTTOM_EDGE: edges.bottom_edge <= cfg_data;
          default: begin
          end
        endcase
      end
      if (eng_ctl.swap) begin
        current_is_b <= ~current_is_b;
      end
      done <= (accept && (cmd.action != ljs_pkg::ACT_SWEEP)) || eng_ctl.done;
      if (accept) begin
        rd_pending <= (cmd.action == ljs_pkg::ACT_READ) && item_ok;
        status     <= ((cmd.action == ljs_pkg::ACT_WRITE) || (cmd.action == ljs_pkg::ACT_READ))
                      && !item_ok;
      end else if (eng_ctl.done) begin
        rd_pending <= 1'b0;
        status     <= 1'b0;
      end
    end
  end

  always_comb begin
    result.read_value = rd_pending ? src_rd0 : '0;
    result.status     = status;
  end

  ljs_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_a (
    .clk      (clk),
    .wr_en    (a_we),
    .wr_addr  (wr_addr_a),
    .wr_data  (wr_data_a),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (eng_rd_addr1),
    .rd_data0 (a_rd0),
    .rd_data1 (a_rd1)
  );

  ljs_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_b (
    .clk      (clk),
    .wr_en    (b_we),
    .wr_addr  (wr_addr_b),
    .wr_data  (wr_data_b),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (eng_rd_addr1),
    .rd_data0 (b_rd0),
    .rd_data1 (b_rd1)
  );

  ljs_sweep_eng #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_sweep (
    .clk      (clk),
    .rst      (rst),
    .start    (sweep_start),
    .w        (w_eff),
    .h        (h_eff),
    .count    (sweep_count),
    .edges    (edges),
    .src_rd0  (src_rd0),
    .src_rd1  (src_rd1),
    .rd_addr0 (eng_rd_addr0),
    .rd_addr1 (eng_rd_addr1),
    .wr_addr  (eng_wr_addr),
    .wr_data  (eng_wr_data),
    .ctl      (eng_ctl)
  );

endmodule

>>> test/laplace_jacobi_grid_solver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplace_jacobi_grid_solver_top_tb
// Drives cell write, read, sweep and no-op items into the Jacobi grid solver
// under several grid sizes, pass counts and edge values. A tracker keeps its
// own copy of both cell stores and predicts each result, and every strobed
// result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module laplace_jacobi_grid_solver_top_tb;
  import ljs_pkg::*;

  localparam int GRID_MAX     = 64;
  localparam int QUIET_LIMIT  = 100000;
  localparam int SWEEP_BUDGET = 20000;
  localparam int SWEEP_CELLS  = 36;

  class grid_tracker;
    logic signed [CELL_W-1:0] cells [2][GRID_MAX*GRID_MAX];
    bit                       known [2][GRID_MAX*GRID_MAX];
    bit                       cur;
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic [COUNT_W-1:0]       passes;
    logic signed [CELL_W-1:0] left_v;
    logic signed [CELL_W-1:0] top_v;
    logic signed [CELL_W-1:0] right_v;
    logic signed [CELL_W-1:0] bottom_v;
    result_t                  awaited [$];
    int                       fails;

    function new();
      cur        = 1'b0;
      width_reg  = RST_GRID_WIDTH;
      height_reg = RST_GRID_HEIGHT;
      passes     = RST_SWEEP_COUNT;
      left_v     = RST_LEFT_EDGE;
      top_v      = RST_TOP_EDGE;
      right_v    = RST_RIGHT_EDGE;
      bottom_v   = RST_BOTTOM_EDGE;
      fails      = 0;
    endfunction

    function int clamp_dim(logic [DIM_W-1:0] d);
      int v;
      v = int'(d);
      if (v < 3) return 3;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function int cols();
      return clamp_dim(width_reg);
    endfunction

    function int rows();
      return clamp_dim(height_reg);
    endfunction

    function bit known_at(int row_i, int col_i);
      return known[cur][row_i*GRID_MAX + col_i];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  width_reg  = data[DIM_W-1:0];
        CFG_GRID_HEIGHT: height_reg = data[DIM_W-1:0];
        CFG_SWEEP_COUNT: passes     = data[COUNT_W-1:0];
        CFG_LEFT_EDGE:   left_v     = data;
        CFG_TOP_EDGE:    top_v      = data;
        CFG_RIGHT_EDGE:  right_v    = data;
        CFG_BOTTOM_EDGE: bottom_v   = data;
        default: ;
      endcase
    endfunction

    // one jacobi pass from the current store into the other one
    function void relax_once();
      int w;
      int h;
      int at;
      int s;
      logic signed [CELL_W-1:0] v;
      bit nxt;
      w = cols();
      h = rows();
      nxt = ~cur;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          at = y*GRID_MAX + x;
          if ((x == 0 || x == w-1) && (y == 0 || y == h-1)) v = '0;
          else if (x == 0) v = left_v;
          else if (y == 0) v = top_v;
          else if (x == w-1) v = right_v;
          else if (y == h-1) v = bottom_v;
          else begin
            s = cells[cur][at-1] + cells[cur][at+1]
              + cells[cur][at-GRID_MAX] + cells[cur][at+GRID_MAX];
            v = CELL_W'(s >>> 2);
          end
          cells[nxt][at] = v;
          known[nxt][at] = 1'b1;
        end
      end
      cur = nxt;
    endfunction

    function void note(cmd_t item);
      result_t r;
      int at;
      r = '0;
      case (item.action)
        ACT_WRITE, ACT_READ: begin
          if (int'(item.col) >= cols() || int'(item.row) >= rows()) begin
            r.status = 1'b1;
          end else begin
            at = int'(item.row)*GRID_MAX + int'(item.col);
            if (item.action == ACT_WRITE) begin
              cells[cur][at] = item.cell_value;
              known[cur][at] = 1'b1;
            end else begin
              r.read_value = cells[cur][at];
            end
          end
        end
        ACT_SWEEP: begin
          for (int i = 0; i < int'(passes); i++) relax_once();
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                 $time, got.read_value, got.status);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch, expected %0d actual %0d",
                 $time, want.read_value, got.read_value);
        fails++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  cmd_t                  cmd;
  logic                  done;
  result_t               result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_tracker tracker;
  bit          gaps_on;
  int          quiet = 0;

  laplace_jacobi_grid_solver_top #(
    .MAX_WIDTH  (GRID_MAX),
    .MAX_HEIGHT (GRID_MAX)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [CELL_W-1:0] any_value();
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      default: return CELL_W'($urandom);
    endcase
  endfunction

  task automatic issue(action_t act, int row_i, int col_i, logic [CELL_W-1:0] v);
    cmd_t item;
    item.action     = act;
    item.row        = COORD_W'(row_i);
    item.col        = COORD_W'(col_i);
    item.cell_value = v;
    while (gaps_on && $urandom_range(0, 99) < 36) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note(item);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic setup(int w, int h, int n, logic [CELL_W-1:0] l, logic [CELL_W-1:0] t,
                       logic [CELL_W-1:0] r, logic [CELL_W-1:0] b);
    logic [CFG_DATA_W-1:0] d;
    settle();
    // unused upper bits carry noise
    d = CFG_DATA_W'($urandom);
    d[DIM_W-1:0] = DIM_W'(w);
    write_reg(CFG_GRID_WIDTH, d);
    d = CFG_DATA_W'($urandom);
    d[DIM_W-1:0] = DIM_W'(h);
    write_reg(CFG_GRID_HEIGHT, d);
    d = CFG_DATA_W'($urandom);
    d[COUNT_W-1:0] = COUNT_W'(n);
    write_reg(CFG_SWEEP_COUNT, d);
    write_reg(CFG_LEFT_EDGE, l);
    write_reg(CFG_TOP_EDGE, t);
    write_reg(CFG_RIGHT_EDGE, r);
    write_reg(CFG_BOTTOM_EDGE, b);
  endtask

  // every neighbour of an interior cell must hold a written value
  task automatic prime_sweep();
    int w;
    int h;
    int nr;
    int nc;
    int dr [4] = '{1, -1, 0, 0};
    int dc [4] = '{0, 0, 1, -1};
    w = tracker.cols();
    h = tracker.rows();
    for (int y = 1; y < h-1; y++) begin
      for (int x = 1; x < w-1; x++) begin
        for (int k = 0; k < 4; k++) begin
          nr = y + dr[k];
          nc = x + dc[k];
          if (!tracker.known_at(nr, nc)) issue(ACT_WRITE, nr, nc, any_value());
        end
      end
    end
  endtask

  task automatic random_item(bit sweeps_ok);
    int w;
    int h;
    int pick;
    int row_i;
    int col_i;
    w = tracker.cols();
    h = tracker.rows();
    pick  = $urandom_range(0, 99);
    row_i = $urandom_range(0, h-1);
    col_i = $urandom_range(0, w-1);
    if (pick < 8) begin
      issue(ACT_NONE, $urandom_range(0, 63), $urandom_range(0, 63), CELL_W'($urandom));
    end else if (pick < 20 && (w < GRID_MAX || h < GRID_MAX)) begin
      // coordinate outside the grid
      if (w < GRID_MAX && (h == GRID_MAX || $urandom_range(0, 1) == 1))
        col_i = $urandom_range(w, GRID_MAX-1);
      else
        row_i = $urandom_range(h, GRID_MAX-1);
      issue($urandom_range(0, 1) == 1 ? ACT_READ : ACT_WRITE, row_i, col_i,
            CELL_W'($urandom));
    end else if (pick < 40 && sweeps_ok) begin
      prime_sweep();
      issue(ACT_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63), CELL_W'($urandom));
    end else if (pick < 70 || !tracker.known_at(row_i, col_i)) begin
      issue(ACT_WRITE, row_i, col_i, any_value());
    end else begin
      issue(ACT_READ, row_i, col_i, CELL_W'($urandom));
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(65, 127);
      2:       return GRID_MAX;
      default: return $urandom_range(3, 9);
    endcase
  endfunction

  initial begin
    bit sweeps_ok;
    int cells_in_use;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    tracker   = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full grid after reset: corner cells with extreme values
    issue(ACT_WRITE, 0, 0, 24'h7FFFFF);
    issue(ACT_WRITE, 63, 63, 24'h800000);
    issue(ACT_WRITE, 63, 0, 24'hFFFFFF);
    issue(ACT_WRITE, 0, 63, 24'h000000);
    issue(ACT_READ, 0, 0, 24'h000000);
    issue(ACT_READ, 63, 63, 24'hFFFFFF);
    issue(ACT_READ, 63, 0, 24'h000000);
    issue(ACT_READ, 0, 63, 24'hFFFFFF);
    issue(ACT_NONE, 63, 63, 24'hFFFFFF);

    // width below range clamps to the smallest grid
    setup(2, 3, 1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001);
    issue(ACT_WRITE, 0, 1, 24'h7FFFFF);
    issue(ACT_WRITE, 2, 1, 24'h7FFFFF);
    issue(ACT_WRITE, 1, 0, 24'h7FFFFF);
    issue(ACT_WRITE, 1, 2, 24'h7FFFFF);
    issue(ACT_WRITE, 0, 3, 24'h123456);
    issue(ACT_READ, 3, 0, 24'h000000);
    issue(ACT_READ, 63, 63, 24'h000000);
    issue(ACT_SWEEP, 1, 1, 24'h000000);
    issue(ACT_READ, 1, 1, 24'h000000);
    issue(ACT_READ, 0, 0, 24'h000000);
    issue(ACT_READ, 1, 0, 24'h000000);
    issue(ACT_WRITE, 0, 1, 24'h800000);
    issue(ACT_WRITE, 2, 1, 24'h800000);
    issue(ACT_WRITE, 1, 0, 24'h800000);
    issue(ACT_WRITE, 1, 2, 24'h800000);
    issue(ACT_SWEEP, 0, 0, 24'h000000);
    issue(ACT_READ, 1, 1, 24'h000000);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: setup(127, 3, 0, any_value(), any_value(), any_value(), any_value());
        1: setup(3, 127, 2, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
        2: setup(64, 3, 65535, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        3: setup(1, 0, 150, any_value(), any_value(), any_value(), any_value());
        default: setup(pick_dim(), pick_dim(), $urandom_range(0, 6),
                       any_value(), any_value(), any_value(), any_value());
      endcase
      gaps_on = (ph != 1) && (ph != 5);
      cells_in_use = tracker.cols() * tracker.rows();
      sweeps_ok = (cells_in_use <= SWEEP_CELLS) &&
                  (int'(tracker.passes) * (2*cells_in_use + 2) <= SWEEP_BUDGET);
      repeat (9) random_item(sweeps_ok);
    end

    settle();
    repeat (20) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
